[design/tlta_pkg.sv]
`default_nettype none
package tlta_pkg;
  localparam int TableDepthDefault = 1024;
  localparam int TimeBitsDefault   = 32;
  localparam int CfgIdxBits        = 3;

  // register indexes
  localparam logic [CfgIdxBits-1:0] REG_GLOBAL_BURST = 3'd0;
  localparam logic [CfgIdxBits-1:0] REG_GLOBAL_RATE  = 3'd1;
  localparam logic [CfgIdxBits-1:0] REG_SOURCE_BURST = 3'd2;
  localparam logic [CfgIdxBits-1:0] REG_SOURCE_RATE  = 3'd3;
  localparam logic [CfgIdxBits-1:0] REG_MAX_SOURCES  = 3'd4;
  localparam logic [CfgIdxBits-1:0] REG_IDLE_EVICT   = 3'd5;

  // verdict codes
  localparam logic [1:0] VERDICT_ADMIT       = 2'd0;
  localparam logic [1:0] VERDICT_SOURCE_EMPTY = 2'd1;
  localparam logic [1:0] VERDICT_TABLE_FULL  = 2'd2;
  localparam logic [1:0] VERDICT_GLOBAL_EMPTY = 2'd3;

  // refill then charge; returns {taken, tokens}
  function automatic logic [8:0] bucket_refill(input logic [7:0] tokens,
      input logic [7:0] burst, input logic [7:0] rate, input logic adv,
      input logic [63:0] delta);
    logic [16:0] t;
    begin
      t = {9'd0, tokens};
      if (adv && rate != 8'd0) begin
        if (delta >= 64'd256) t = {9'd0, burst};
        else t = t + 17'(delta[7:0]) * 17'(rate);
      end
      if (adv && t > {9'd0, burst}) t = {9'd0, burst};
      bucket_refill = {t[7:0] != 8'd0, t[7:0] - 8'(t[7:0] != 8'd0)};
    end
  endfunction
endpackage
`default_nettype wire

[design/tlta_table.sv]
`default_nettype none
// source table memory: valid, key, tokens, last refill, last use; one read and one write port
module tlta_table
  import tlta_pkg::*;
#(
  parameter int TableDepth = TableDepthDefault,
  parameter int TimeBits   = TimeBitsDefault
) (
  input  wire logic                          clk,
  input  wire logic [$clog2(TableDepth)-1:0] raddr,
  output logic                               rvalid,
  output logic [255:0]                       rkey,
  output logic [7:0]                         rtokens,
  output logic [TimeBits-1:0]                rrefill,
  output logic [TimeBits-1:0]                ruse,
  input  wire logic                          we,
  input  wire logic [$clog2(TableDepth)-1:0] waddr,
  input  wire logic                          wvalid,
  input  wire logic [255:0]                  wkey,
  input  wire logic [7:0]                    wtokens,
  input  wire logic [TimeBits-1:0]           wrefill,
  input  wire logic [TimeBits-1:0]           wuse
);
  localparam int W = 1 + 256 + 8 + 2 * TimeBits;
  logic [W-1:0] mem [TableDepth];
  logic [W-1:0] rdata;

  // synchronous read, write
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
    if (we) begin
      mem[waddr] <= {wvalid, wkey, wtokens, wrefill, wuse};
    end
  end

  assign {rvalid, rkey, rtokens, rrefill, ruse} = rdata;
endmodule
`default_nettype wire

[design/two_level_token_bucket_admission.sv]
`default_nettype none
// Per-source token-bucket policer with a global bucket behind it. Every request
// word returns exactly one result word: tdata[1:0] verdict (0 admit, 1 source
// empty, 2 table full, 3 global empty), tdata[2] evicted. The source table, valid
// bits included, lives in one synchronous memory; each request walks it one entry
// per cycle (lookup, longest-idle search and free slot found in the same pass).
// The walk is followed by a decision step, a read step and a read-modify-write
// step that presents the result word; a table-full rejection is presented from
// the decision step. The next request is taken the cycle after the result word
// leaves; a stalled result holds the input off for as long as it waits. After
// reset a clearing pass marks every entry invalid, with the input held off
// meanwhile.
module two_level_token_bucket_admission
  import tlta_pkg::*;
#(
  parameter int TableDepth = TableDepthDefault,
  parameter int TimeBits   = TimeBitsDefault
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  // source_word0, source_word1, source_word2, source_word3, now_seconds
  input  wire logic [287:0]          s_tdata,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  // verdict, evicted_entry
  output logic [7:0]                 m_tdata,
  input  wire logic                  cfg_we,
  input  wire logic [CfgIdxBits-1:0] cfg_index,
  input  wire logic [15:0]           cfg_data
);
  localparam int AW = $clog2(TableDepth);
  localparam int CW = AW + 1;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SCAN  = 3'd1;
  localparam logic [2:0] ST_RD    = 3'd2;
  localparam logic [2:0] ST_WAIT  = 3'd3;
  localparam logic [2:0] ST_UPD   = 3'd4;
  localparam logic [2:0] ST_CLEAR = 3'd5;

  logic [7:0]  global_burst, global_rate, source_burst, source_rate;
  logic [10:0] max_sources;
  logic [15:0] idle_evict;

  logic [2:0]          state;
  logic [CW-1:0]       count;
  logic [7:0]          gtokens;
  logic [TimeBits-1:0] glast;

  logic [255:0]        key;
  logic [TimeBits-1:0] now;
  logic [CW-1:0]       ptr;     // address issued
  logic                rd_v;
  logic [AW-1:0]       rd_a;
  logic                hit;
  logic [AW-1:0]       hit_a;
  logic                vic;
  logic [AW-1:0]       vic_a;
  logic [TimeBits-1:0] oldest;
  logic                fre;
  logic [AW-1:0]       free_a;

  logic [AW-1:0]       raddr;
  logic                rvalid;
  logic [255:0]        rkey;
  logic [7:0]          rtokens;
  logic [TimeBits-1:0] rrefill, ruse;
  logic                we;
  logic                evict_we;
  logic [AW-1:0]       waddr;
  logic                wvalid;
  logic [7:0]          wtokens;
  logic [TimeBits-1:0] wrefill;

  tlta_table #(.TableDepth(TableDepth), .TimeBits(TimeBits)) u_table (
    .clk(clk), .raddr(raddr),
    .rvalid(rvalid), .rkey(rkey), .rtokens(rtokens), .rrefill(rrefill), .ruse(ruse),
    .we(we), .waddr(waddr), .wvalid(wvalid), .wkey(key), .wtokens(wtokens),
    .wrefill(wrefill), .wuse(now)
  );

  assign s_tready = (state == ST_IDLE) && !m_tvalid;

  // read the matched or chosen entry once the walk is over
  assign raddr = (state == ST_RD || state == ST_WAIT) ? hit_a : ptr[AW-1:0];

  // decision after scan
  logic [31:0] limit;
  logic        full;
  logic        can_evict;
  logic        can_place;
  logic [AW-1:0] slot;
  logic [TimeBits-1:0] idle_gap;
  assign limit = (32'(max_sources) < 32'(TableDepth)) ? 32'(max_sources) : 32'(TableDepth);
  assign full = 32'(count) >= limit;
  assign idle_gap = now - oldest;
  assign can_evict = vic && (64'(idle_gap) >= 64'(idle_evict));
  assign can_place = full ? can_evict : fre;
  // full table: victim's slot or lowest free slot, whichever is lower; else lowest free slot
  assign slot = (full && (!fre || vic_a < free_a)) ? vic_a : free_a;

  // bucket updates
  logic [8:0] src_b, glb_b;
  logic [7:0] src_tok;
  logic [TimeBits-1:0] src_last;
  logic new_entry;
  assign src_tok  = new_entry ? source_burst : rtokens;
  assign src_last = new_entry ? now : rrefill;
  assign src_b = bucket_refill(src_tok, source_burst, source_rate, now > src_last,
                               64'(now - src_last));
  assign glb_b = bucket_refill(gtokens, global_burst, global_rate, now > glast,
                               64'(now - glast));

  // memory writes: clearing pass, victim invalidation, entry update
  assign evict_we = (state == ST_RD) && !hit && full && can_evict;
  assign we       = (state == ST_UPD) || (state == ST_CLEAR) || evict_we;
  assign wvalid   = (state == ST_UPD);
  always_comb begin
    case (state)
      ST_CLEAR: waddr = ptr[AW-1:0];
      ST_RD:    waddr = vic_a;
      default:  waddr = hit_a;
    endcase
  end
  assign wtokens = src_b[7:0];
  assign wrefill = (now > src_last) ? now : src_last;

  logic evicted;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      global_burst <= 8'd16;
      global_rate  <= 8'd4;
      source_burst <= 8'd1;
      source_rate  <= 8'd1;
      max_sources  <= 11'd1000;
      idle_evict   <= 16'd300;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GLOBAL_BURST: global_burst <= cfg_data[7:0];
        REG_GLOBAL_RATE:  global_rate  <= cfg_data[7:0];
        REG_SOURCE_BURST: source_burst <= cfg_data[7:0];
        REG_SOURCE_RATE:  source_rate  <= cfg_data[7:0];
        REG_MAX_SOURCES:  max_sources  <= cfg_data[10:0];
        REG_IDLE_EVICT:   idle_evict   <= cfg_data;
        default: ;
      endcase
    end
  end

  // control sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      ptr      <= '0;
      count    <= '0;
      gtokens  <= 8'd16;
      glast    <= '0;
      m_tvalid <= 1'b0;
      rd_v     <= 1'b0;
    end else begin
      case (state)
        ST_CLEAR: begin
          // one entry marked invalid per cycle
          ptr <= ptr + 1'b1;
          if (ptr == CW'(TableDepth - 1)) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (m_tvalid && m_tready) m_tvalid <= 1'b0;
          if (s_tvalid && s_tready) begin
            key    <= s_tdata[255:0];
            now    <= TimeBits'(s_tdata[287:256]);
            oldest <= TimeBits'(s_tdata[287:256]);
            ptr    <= '0;
            rd_v   <= 1'b0;
            hit    <= 1'b0;
            vic    <= 1'b0;
            fre    <= 1'b0;
            state  <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          // issue next read, examine last read
          rd_v <= (ptr < CW'(TableDepth));
          rd_a <= ptr[AW-1:0];
          if (ptr < CW'(TableDepth)) ptr <= ptr + 1'b1;
          if (rd_v) begin
            if (rvalid) begin
              if (!hit && rkey == key) begin
                hit   <= 1'b1;
                hit_a <= rd_a;
              end
              if (ruse < oldest) begin
                oldest <= ruse;
                vic    <= 1'b1;
                vic_a  <= rd_a;
              end
            end else if (!fre) begin
              fre    <= 1'b1;
              free_a <= rd_a;
            end
          end
          if (!rd_v && ptr == CW'(TableDepth)) state <= ST_RD;
        end
        ST_RD: begin
          if (hit) begin
            evicted   <= 1'b0;
            new_entry <= 1'b0;
            state     <= ST_WAIT;
          end else if (!can_place) begin
            m_tdata  <= {6'd0, VERDICT_TABLE_FULL};
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end else begin
            // a full table keeps its count: one entry out, one in
            if (!full) count <= count + 1'b1;
            evicted   <= full;
            new_entry <= 1'b1;
            hit_a     <= slot;
            state     <= ST_WAIT;
          end
        end
        ST_WAIT: state <= ST_UPD;
        ST_UPD: begin
          if (!src_b[8]) begin
            m_tdata <= {5'd0, evicted, VERDICT_SOURCE_EMPTY};
          end else begin
            gtokens <= glb_b[7:0];
            if (now > glast) glast <= now;
            m_tdata <= {5'd0, evicted, glb_b[8] ? VERDICT_ADMIT : VERDICT_GLOBAL_EMPTY};
          end
          m_tvalid <= 1'b1;
          state    <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

[sim/tb_two_level_token_bucket_admission.sv]
`timescale 1ns / 100ps
module tb_two_level_token_bucket_admission;
  import tlta_pkg::*;

  localparam int Depth = TableDepthDefault;

  typedef struct packed {
    logic [1:0] verdict;
    logic       evicted;
  } verdict_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [287:0]          s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [7:0]            m_tdata;
  logic                  cfg_we = 1'b0;
  logic [CfgIdxBits-1:0] cfg_index = '0;
  logic [15:0]           cfg_data = '0;

  two_level_token_bucket_admission DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // policer shadow state
  logic [7:0]   sh_gburst, sh_grate, sh_sburst, sh_srate;
  logic [10:0]  sh_max_src;
  logic [15:0]  sh_idle;
  logic         tab_valid [Depth];
  logic [255:0] tab_key [Depth];
  logic [7:0]   tab_tokens [Depth];
  logic [31:0]  tab_refill [Depth];
  logic [31:0]  tab_use [Depth];
  int           tab_count;
  logic [7:0]   glob_tokens;
  logic [31:0]  glob_refill;

  verdict_t     verdict_q[$];
  int           errors = 0;
  int           send_idle_pct = 0;
  int           recv_stall_pct = 0;
  int           hold_start = 0;
  int           hold_left = 0;
  logic [31:0]  cur_t = 0;
  logic [255:0] id_pool [12];

  // refill then take one token
  function automatic logic bucket_charge(ref logic [7:0] tokens, ref logic [31:0] last,
                                         input logic [7:0] burst, input logic [7:0] rate,
                                         input logic [31:0] now);
    int t;
    if (now > last) begin
      t = tokens;
      if (rate != 0) begin
        if (now - last >= 256) t = burst;
        else t = t + int'(now - last) * rate;
      end
      tokens = (t < burst) ? t[7:0] : burst;
      last = now;
    end
    if (tokens == 0) return 1'b0;
    tokens = tokens - 8'd1;
    return 1'b1;
  endfunction

  task automatic admit_predict(input logic [255:0] id, input logic [31:0] now);
    int limit, hit, victim, slot;
    logic [31:0] oldest;
    verdict_t v;
    limit = (sh_max_src < Depth) ? sh_max_src : Depth;
    hit = -1;
    v.evicted = 1'b0;
    for (int i = 0; i < Depth; i++)
      if (hit < 0 && tab_valid[i] && tab_key[i] == id) hit = i;
    if (hit < 0) begin
      if (tab_count >= limit) begin
        victim = -1;
        oldest = now;
        for (int i = 0; i < Depth; i++)
          if (tab_valid[i] && tab_use[i] < oldest) begin
            oldest = tab_use[i];
            victim = i;
          end
        if (victim >= 0 && (now - oldest) >= {16'd0, sh_idle}) begin
          tab_valid[victim] = 1'b0;
          if (tab_count > 0) tab_count--;
          v.evicted = 1'b1;
        end else begin
          v.verdict = VERDICT_TABLE_FULL;
          v.evicted = 1'b0;
          verdict_q.push_back(v);
          return;
        end
      end
      slot = -1;
      for (int i = 0; i < Depth; i++)
        if (slot < 0 && !tab_valid[i]) slot = i;
      if (slot < 0) begin
        v.verdict = VERDICT_TABLE_FULL;
        verdict_q.push_back(v);
        return;
      end
      hit = slot;
      tab_valid[hit] = 1'b1;
      tab_key[hit] = id;
      tab_tokens[hit] = sh_sburst;
      tab_refill[hit] = now;
      tab_count++;
    end
    tab_use[hit] = now;
    if (!bucket_charge(tab_tokens[hit], tab_refill[hit], sh_sburst, sh_srate, now))
      v.verdict = VERDICT_SOURCE_EMPTY;
    else if (!bucket_charge(glob_tokens, glob_refill, sh_gburst, sh_grate, now))
      v.verdict = VERDICT_GLOBAL_EMPTY;
    else
      v.verdict = VERDICT_ADMIT;
    verdict_q.push_back(v);
  endtask

  // send one request word, with an optional random gap before it
  task automatic send_req(input logic [255:0] id, input logic [31:0] now);
    if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
      @(negedge clk) s_tvalid <= 1'b0;
      while ($urandom_range(0, 99) < send_idle_pct) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata <= {now, id};
    do @(posedge clk); while (!s_tready);
    admit_predict(id, now);
  endtask

  task automatic drain();
    @(negedge clk) s_tvalid <= 1'b0;
    wait (verdict_q.size() == 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CfgIdxBits-1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk) cfg_we <= 1'b0;
    case (idx)
      REG_GLOBAL_BURST: sh_gburst = val[7:0];
      REG_GLOBAL_RATE:  sh_grate = val[7:0];
      REG_SOURCE_BURST: sh_sburst = val[7:0];
      REG_SOURCE_RATE:  sh_srate = val[7:0];
      REG_MAX_SOURCES:  sh_max_src = val[10:0];
      REG_IDLE_EVICT:   sh_idle = val;
      default: ;
    endcase
  endtask

  task automatic cfg_all(input int gb, gr, sb, sr, ms, idl);
    cfg_write(REG_GLOBAL_BURST, 16'(gb));
    cfg_write(REG_GLOBAL_RATE, 16'(gr));
    cfg_write(REG_SOURCE_BURST, 16'(sb));
    cfg_write(REG_SOURCE_RATE, 16'(sr));
    cfg_write(REG_MAX_SOURCES, 16'(ms));
    cfg_write(REG_IDLE_EVICT, 16'(idl));
  endtask

  function automatic logic [255:0] rand_id();
    return {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
  endfunction

  // receiver ready, with long hold-off on request
  always @(negedge clk) begin
    if (hold_start > 0) begin
      hold_left = hold_start;
      hold_start = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // result word check
  always @(posedge clk) begin
    verdict_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (verdict_q.size() == 0) begin
        $display("%0t: unexpected result word %h", $time, m_tdata);
        errors++;
      end else begin
        e = verdict_q.pop_front();
        if (m_tdata[1:0] !== e.verdict) begin
          $display("%0t: verdict expected %0d actual %0d", $time, e.verdict, m_tdata[1:0]);
          errors++;
        end
        if (m_tdata[2] !== e.evicted) begin
          $display("%0t: evicted expected %0d actual %0d", $time, e.evicted, m_tdata[2]);
          errors++;
        end
      end
    end
  end

  // bucket refill, saturation and time standing still
  task automatic test_buckets();
    logic [255:0] a;
    a = '0;
    send_req(a, 0);
    send_req(a, 0);
    send_req(a, 1);
    send_req('1, 1);
    drain();
    cfg_all(2, 0, 255, 255, 1000, 300);
    send_req('1, 5);
    send_req('1, 5);
    send_req('1, 6);
    send_req('1, 400);
    drain();
    cfg_all(255, 255, 0, 0, 1000, 300);
    send_req(256'h5, 401);
    send_req(256'h5, 900);
    drain();
    cur_t = 900;
  endtask

  // table limit, idle eviction and zero limit
  task automatic test_eviction();
    cfg_all(255, 255, 3, 1, 2, 5);
    send_req(256'h11, 1000);
    send_req(256'h12, 1000);
    send_req(256'h13, 1002);
    send_req(256'h13, 1010);
    send_req(256'h12, 1011);
    drain();
    cfg_all(255, 255, 3, 1, 0, 0);
    send_req(256'h14, 1011);
    send_req(256'h15, 1012);
    drain();
    cfg_write(3'd6, 16'hFFFF);
    cfg_write(3'd7, 16'h0000);
    cfg_all(255, 255, 3, 1, 2047, 65535);
    send_req(256'h16, 1013);
    drain();
    cur_t = 1013;
  endtask

  // random config and traffic over a small source pool
  task automatic test_random_phase(input int n, input int idle_pct, input int stall_pct);
    int r, ms;
    logic [255:0] id;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    r = $urandom_range(0, 3);
    ms = (r == 0) ? $urandom_range(0, 2047) : (1 << $urandom_range(0, 3));
    cfg_all($urandom_range(0, 3) == 0 ? 255 : $urandom_range(1, 20), $urandom_range(0, 255),
            $urandom_range(0, 3) == 0 ? 255 : $urandom_range(0, 6), $urandom_range(0, 4),
            ms, $urandom_range(0, 3) == 0 ? 65535 : $urandom_range(0, 30));
    for (int i = 0; i < 12; i++) id_pool[i] = rand_id();
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 3) cur_t = cur_t + $urandom_range(256, 5000);
      else if (r < 40) cur_t = cur_t + $urandom_range(1, 8);
      id = ($urandom_range(0, 9) == 0) ? rand_id() : id_pool[$urandom_range(0, 11)];
      send_req(id, cur_t);
    end
    drain();
  endtask

  // long receiver hold-off fills the block, then sender waits for all results
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_start = 6000;
    for (int k = 0; k < 6; k++) send_req(id_pool[k], cur_t + k);
    cur_t = cur_t + 6;
    drain();
  endtask

  // extreme identifiers and the top of the time range
  task automatic test_extremes();
    cfg_all(1, 255, 1, 255, 1, 0);
    send_req('0, 32'hFFFF0000);
    send_req('1, 32'hFFFFFFFE);
    send_req('1, 32'hFFFFFFFF);
    send_req({4{64'hAAAA_5555_AAAA_5555}}, 32'hFFFFFFFF);
    drain();
  endtask

  initial begin
    cfg_write(REG_GLOBAL_BURST, 16'd16);
    sh_gburst = 16; sh_grate = 4; sh_sburst = 1; sh_srate = 1;
    sh_max_src = 1000; sh_idle = 300;
    tab_count = 0; glob_tokens = 16; glob_refill = 0;
    for (int i = 0; i < Depth; i++) tab_valid[i] = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
    test_buckets();
    test_eviction();
    test_random_phase(100, 0, 0);
    test_random_phase(95, 86, 0);
    test_random_phase(95, 0, 86);
    test_random_phase(95, 19, 19);
    test_backpressure();
    test_random_phase(95, 0, 0);
    test_random_phase(90, 19, 19);
    test_extremes();
    repeat (40) @(posedge clk);
    if (errors == 0) $display("tb_two_level_token_bucket_admission: PASS");
    else $display("tb_two_level_token_bucket_admission: FAIL");
    $finish;
  end

  initial begin
    #40000000;
    $display("tb_two_level_token_bucket_admission: FAIL");
    $finish;
  end
endmodule
